FILE: rtl/carvb_pkg.sv
`default_nettype none

package carvb_pkg;

  localparam int NUM_COMB = 4;
  localparam int NUM_DIF  = 2;

  localparam int COMB_LEN_A     = 1117;
  localparam int COMB_LEN_B     = 1189;
  localparam int COMB_LEN_C     = 1278;
  localparam int COMB_LEN_D     = 1357;
  localparam int DIFFUSER_LEN_A = 557;
  localparam int DIFFUSER_LEN_B = 442;

  localparam int COMB_LEN_TBL [NUM_COMB] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
  localparam int DIF_LEN_TBL  [NUM_DIF]  = '{DIFFUSER_LEN_A, DIFFUSER_LEN_B};

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 24;
  localparam int FB_W     = 16;
  localparam int DAMP_W   = 15;
  localparam int MIX_W    = 17;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 17;

  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  typedef enum logic [CFG_AW-1:0] {
    REG_FEEDBACK = 2'd0,
    REG_DAMPING  = 2'd1,
    REG_WET_MIX  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAMP_MUL,
    ST_DAMP,
    ST_FB_MUL,
    ST_FB,
    ST_AVG,
    ST_DIF_V,
    ST_DIF_W,
    ST_MIX_MUL,
    ST_OUT
  } state_t;

  // saturate a 28-bit value to a 24-bit delay word
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    if (v > 28'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -28'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // product scaled by 2^-16, round half up
  function automatic logic signed [26:0] rnd16(input logic signed [42:0] v);
    logic signed [42:0] t;
    t = v + 43'sd32768;
    return t[42:16];
  endfunction

  // word halved, round half up
  function automatic logic signed [23:0] rnd_half(input logic signed [23:0] v);
    logic signed [24:0] t;
    t = 25'(v) + 25'sd1;
    return t[24:1];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/carvb_in_if.sv
`default_nettype none

interface carvb_in_if import carvb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/carvb_out_if.sv
`default_nettype none

interface carvb_out_if import carvb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/carvb_cfg_if.sv
`default_nettype none

interface carvb_cfg_if import carvb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/comb_allpass_reverb.sv
`default_nettype none

// Schroeder-style reverb: four damped feedback combs, averaged, then two
// allpass diffusers (gain 1/2), crossfaded with the dry sample. One sample is
// taken on din; din is ready only while the sequencer is idle, so no new
// sample is taken until the last one has passed all steps. The steps share
// one 25x18 multiplier: per comb a damping multiply, damping update, feedback
// multiply and line write; then the average; per diffuser a line write and
// an update; then the final mix multiply and output. A finished result waits
// in the dout register, so a new sample can be accepted while it is pending;
// if the next result is done before the pending one is read, the sequencer
// holds until dout is free. Delay lines read as zero until their position has
// been written once, so no clearing pass follows reset. Configuration writes
// are always taken; index 3 is ignored.
module comb_allpass_reverb import carvb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  carvb_in_if.sink     din,
  carvb_out_if.source  dout,
  carvb_cfg_if.sink    cfg
);

  state_t state, state_next;

  logic [1:0] k;
  logic       j;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [26:0]         sum;
  logic signed [WORD_W-1:0]   w;
  logic signed [WORD_W-1:0]   v;
  logic signed [42:0]         p;
  logic signed [WORD_W-1:0]   damp [NUM_COMB];

  logic [FB_W-1:0]   feedback_coef;
  logic [DAMP_W-1:0] damping_coef;
  logic [MIX_W-1:0]  wet_mix;
  logic [MIX_W-1:0]  mix_eff;

  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       out_valid;

  logic                rd_en;
  logic [NUM_COMB-1:0] comb_we;
  logic [NUM_DIF-1:0]  dif_we;

  logic signed [WORD_W-1:0] comb_rd [NUM_COMB];
  logic [NUM_COMB-1:0]      comb_ok;
  logic signed [WORD_W-1:0] comb_o  [NUM_COMB];
  logic signed [WORD_W-1:0] dif_rd  [NUM_DIF];
  logic [NUM_DIF-1:0]       dif_ok;
  logic signed [WORD_W-1:0] dif_o;

  logic signed [WORD_W-1:0] comb_wdata;
  logic signed [WORD_W-1:0] v_next;
  logic signed [24:0]       mul_a;
  logic signed [17:0]       mul_b;

  logic accept;
  logic out_take;
  logic out_load;

  assign accept   = din.valid && din.ready;
  assign out_take = out_valid && dout.ready;
  assign out_load = (state == ST_OUT) && (!out_valid || dout.ready);

  assign dout.valid      = out_valid;
  assign dout.sample_out = sample_out;
  assign cfg.ready       = 1'b1;

  // ---------------- delay lines ----------------
  for (genvar gk = 0; gk < NUM_COMB; gk++) begin : g_comb
    localparam int Len = COMB_LEN_TBL[gk];
    localparam int Aw  = $clog2(Len);

    logic signed [WORD_W-1:0] line [Len];
    logic [Aw-1:0]            idx;
    logic                     full;

    always_ff @(posedge clk) begin
      if (comb_we[gk]) begin
        line[idx] <= comb_wdata;
      end
      if (rd_en) begin
        comb_rd[gk] <= line[idx];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        idx         <= '0;
        full        <= 1'b0;
        comb_ok[gk] <= 1'b0;
      end else begin
        if (rd_en) begin
          comb_ok[gk] <= full;
        end
        if (comb_we[gk]) begin
          if (idx == Aw'(Len - 1)) begin
            idx  <= '0;
            full <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
    end
  end

  for (genvar gd = 0; gd < NUM_DIF; gd++) begin : g_dif
    localparam int Len = DIF_LEN_TBL[gd];
    localparam int Aw  = $clog2(Len);

    logic signed [WORD_W-1:0] line [Len];
    logic [Aw-1:0]            idx;
    logic                     full;

    always_ff @(posedge clk) begin
      if (dif_we[gd]) begin
        line[idx] <= v_next;
      end
      if (rd_en) begin
        dif_rd[gd] <= line[idx];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        idx        <= '0;
        full       <= 1'b0;
        dif_ok[gd] <= 1'b0;
      end else begin
        if (rd_en) begin
          dif_ok[gd] <= full;
        end
        if (dif_we[gd]) begin
          if (idx == Aw'(Len - 1)) begin
            idx  <= '0;
            full <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
    end
  end

  // never-written positions read as zero
  always_comb begin
    for (int i = 0; i < NUM_COMB; i++) begin
      comb_o[i] = comb_ok[i] ? comb_rd[i] : '0;
    end
    dif_o = dif_ok[j] ? dif_rd[j] : '0;
  end

  // ---------------- datapath ----------------
  assign mix_eff    = (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;
  assign comb_wdata = sat24(28'(x) + 28'(rnd16(p)));
  assign v_next     = sat24(28'(w) + 28'(rnd_half(dif_o)));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DAMP_MUL: begin
        mul_a = 25'(damp[k]) - 25'(comb_o[k]);
        mul_b = 18'(damping_coef);
      end
      ST_FB_MUL: begin
        mul_a = 25'(damp[k]);
        mul_b = 18'(feedback_coef);
      end
      ST_MIX_MUL: begin
        mul_a = 25'(w) - 25'(x);
        mul_b = 18'(mix_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // mix product must survive while the result waits for dout
    if (state != ST_OUT) begin
      p <= mul_a * mul_b;
    end
    if (accept) begin
      x <= din.sample_in;
    end
    if (state == ST_DAMP) begin
      damp[k] <= sat24(28'(comb_o[k]) + 28'(rnd16(p)));
    end
    if (state == ST_AVG) begin
      w <= sat24(28'((sum + 27'sd2) >>> 2));
    end
    if (state == ST_DIF_V) begin
      v <= v_next;
    end
    if (state == ST_DIF_W) begin
      w <= sat24(28'(dif_o) - 28'(rnd_half(v)));
    end
    if (out_load) begin
      sample_out <= sat16(28'(x) + 28'(rnd16(p)));
    end
    if (rst) begin
      for (int i = 0; i < NUM_COMB; i++) begin
        damp[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      j   <= 1'b0;
      sum <= '0;
    end else begin
      if (accept) begin
        k   <= '0;
        j   <= 1'b0;
        sum <= '0;
      end
      if (state == ST_FB) begin
        sum <= sum + 27'(comb_o[k]);
        k   <= k + 1'b1;
      end
      if (state == ST_DIF_W) begin
        j <= ~j;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_coef <= 16'd55050;
      damping_coef  <= 15'd13107;
      wet_mix       <= 17'd19661;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FEEDBACK: feedback_coef <= cfg.data[FB_W-1:0];
        REG_DAMPING:  damping_coef  <= cfg.data[DAMP_W-1:0];
        REG_WET_MIX:  wet_mix       <= cfg.data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (din.valid) state_next = ST_DAMP_MUL;
      ST_DAMP_MUL: state_next = ST_DAMP;
      ST_DAMP:     state_next = ST_FB_MUL;
      ST_FB_MUL:   state_next = ST_FB;
      ST_FB:       state_next = (k == 2'(NUM_COMB - 1)) ? ST_AVG : ST_DAMP_MUL;
      ST_AVG:      state_next = ST_DIF_V;
      ST_DIF_V:    state_next = ST_DIF_W;
      ST_DIF_W:    state_next = j ? ST_MIX_MUL : ST_DIF_V;
      ST_MIX_MUL:  state_next = ST_OUT;
      ST_OUT:      if (!out_valid || dout.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready = 1'b0;
    rd_en     = 1'b0;
    comb_we   = '0;
    dif_we    = '0;
    unique case (state)
      ST_IDLE: begin
        din.ready = 1'b1;
        rd_en     = din.valid;
      end
      ST_FB:    comb_we = NUM_COMB'(1) << k;
      ST_DIF_V: dif_we  = NUM_DIF'(1) << j;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
